FILE: rtl/assert_macros.svh
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on a named clock, disabled while the named reset is low
`define TCW_ASSERT_CLK(lbl, clk_sig, rst_sig, prop, msg) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rst_sig) prop) else $error(msg);

// concurrent assertion on the usual clk and rst_n
`define TCW_ASSERT(lbl, prop, msg) \
    `TCW_ASSERT_CLK(lbl, clk, rst_n, prop, msg)

`endif

FILE: rtl/tcw_pkg.sv
// shared types and constants for the text console cell writer
package tcw_pkg;

    // port field widths
    localparam int KIND_W  = 3;
    localparam int CHAR_W  = 8;
    localparam int PROW_W  = 5;
    localparam int PCOL_W  = 7;
    localparam int ATTR_W  = 8;
    localparam int LINES_W = 5;
    localparam int CELL_W  = 16;

    typedef logic [CELL_W-1:0] cell_t;

    // command kinds
    localparam logic [KIND_W-1:0] KIND_PUT    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SETCUR = 3'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_WRITE  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SCRUP  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_SCRDN  = 3'd5;
    localparam logic [KIND_W-1:0] KIND_READ   = 3'd6;

    // character codes
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;

    // cell values and attributes
    localparam cell_t             CLEAR_CELL = 16'h0720;
    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

    // sweep modes
    localparam logic [1:0] SWP_FILL = 2'd0;
    localparam logic [1:0] SWP_UP   = 2'd1;
    localparam logic [1:0] SWP_DOWN = 2'd2;

    // sweep request from the command control to the sweep engine
    typedef struct packed {
        logic               start;
        logic [1:0]         mode;
        logic [LINES_W-1:0] lines;
    } swp_cmd_t;

endpackage

FILE: rtl/tcw_ifs.sv
// command and result channel interfaces
interface tcw_cmd_if import tcw_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [CHAR_W-1:0]  char_code;
    logic [PROW_W-1:0]  row;
    logic [PCOL_W-1:0]  col;
    logic [ATTR_W-1:0]  cell_attribute;
    logic [LINES_W-1:0] line_count;

    modport source (output valid, kind, char_code, row, col, cell_attribute, line_count,
                    input ready);
    modport sink   (input valid, kind, char_code, row, col, cell_attribute, line_count,
                    output ready);
endinterface

interface tcw_res_if import tcw_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [PROW_W-1:0] cursor_row_out;
    logic [PCOL_W-1:0] cursor_col_out;
    logic [CELL_W-1:0] cell_value;
    logic              position_error;

    modport source (output valid, cursor_row_out, cursor_col_out, cell_value, position_error,
                    input ready);
    modport sink   (input valid, cursor_row_out, cursor_col_out, cell_value, position_error,
                    output ready);
endinterface

FILE: rtl/tcw_ram.sv
// generic simple dual port ram with registered read
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/tcw_sweep.sv
// sweep engine: fill, scroll up and scroll down over the whole cell store
module tcw_sweep import tcw_pkg::*; #(
    parameter int ROWS    = 25,
    parameter int COLUMNS = 80,
    localparam int ROW_W  = $clog2(ROWS),
    localparam int COL_W  = $clog2(COLUMNS),
    localparam int ADDR_W = $clog2(ROWS * COLUMNS)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  swp_cmd_t          cmd,
    input  cell_t             blank,
    input  cell_t             rd_data,
    output logic              rd_en,
    output logic [ADDR_W-1:0] rd_addr,
    output logic              wr_en,
    output logic [ADDR_W-1:0] wr_addr,
    output cell_t             wr_data,
    output logic              done
);

    function automatic logic [ADDR_W-1:0] addr_of(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
        return ADDR_W'(ADDR_W'(r) * ADDR_W'(COLUMNS) + ADDR_W'(c));
    endfunction

    logic               active_reg;
    logic [1:0]         mode_reg;
    logic [LINES_W-1:0] lines_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [COL_W-1:0]   col_reg;
    logic               b_valid_reg;
    logic               b_last_reg;
    logic [ADDR_W-1:0]  b_addr_reg;
    logic               b_ok_reg;
    logic               b_fill_reg;

    logic [LINES_W:0]   src_sum;
    logic [LINES_W-1:0] src_dn;
    logic               src_ok;
    logic [ROW_W-1:0]   src_row;
    logic               last_col;
    logic               last_row;

    // source row for the current destination row
    always_comb
    begin
        src_sum = (LINES_W+1)'(row_reg) + (LINES_W+1)'(lines_reg);
        src_dn  = LINES_W'(row_reg) - lines_reg;
        src_ok  = 1'b0;
        src_row = src_sum[ROW_W-1:0];
        unique case (mode_reg)
            SWP_UP:
            begin
                src_ok  = 32'(src_sum) < ROWS;
                src_row = src_sum[ROW_W-1:0];
            end
            SWP_DOWN:
            begin
                src_ok  = LINES_W'(row_reg) >= lines_reg;
                src_row = src_dn[ROW_W-1:0];
            end
            default:
            begin
                src_ok = 1'b0;
            end
        endcase
    end

    assign last_col = col_reg == COL_W'(COLUMNS - 1);
    assign last_row = (mode_reg == SWP_DOWN) ? (row_reg == '0) : (row_reg == ROW_W'(ROWS - 1));

    // destination walk: rows ascending for fill and up, descending for down
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else if (cmd.start)
        begin
            active_reg <= 1'b1;
        end
        else if (active_reg && last_col && last_row)
        begin
            active_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            mode_reg  <= cmd.mode;
            lines_reg <= (cmd.lines == '0) ? LINES_W'(1) : cmd.lines;
            row_reg   <= (cmd.mode == SWP_DOWN) ? ROW_W'(ROWS - 1) : '0;
            col_reg   <= '0;
        end
        else if (active_reg)
        begin
            if (last_col)
            begin
                col_reg <= '0;
                if (!last_row)
                begin
                    row_reg <= (mode_reg == SWP_DOWN) ? row_reg - 1'b1 : row_reg + 1'b1;
                end
            end
            else
            begin
                col_reg <= col_reg + 1'b1;
            end
        end
    end

    // write stage, in the cycle after the read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            b_last_reg  <= 1'b0;
        end
        else
        begin
            b_valid_reg <= active_reg;
            b_last_reg  <= active_reg && last_col && last_row;
        end
    end

    always_ff @(posedge clk)
    begin
        b_addr_reg <= addr_of(row_reg, col_reg);
        b_ok_reg   <= src_ok;
        b_fill_reg <= mode_reg == SWP_FILL;
    end

    assign rd_en   = active_reg && src_ok;
    assign rd_addr = addr_of(src_row, col_reg);
    assign wr_en   = b_valid_reg;
    assign wr_addr = b_addr_reg;
    assign wr_data = b_fill_reg ? CLEAR_CELL : (b_ok_reg ? rd_data : blank);
    assign done    = b_valid_reg && b_last_reg;

endmodule

FILE: rtl/text_console_cell_writer.sv
// text console cell writer top level: command control, cursor and cell store
//
//  channel  dir  handshake      payload
//  cmd      in   valid/ready    kind, char_code, row, col, cell_attribute, line_count
//  res      out  valid/ready    cursor_row_out, cursor_col_out, cell_value, position_error
//  cfg      in   cfg_we         cfg_wdata (text attribute)
//
// put char, set cursor, write cell: result registered in the cycle after the beat
// read cell: through the registered read port of the cell ram, then the result register
// clear and scroll (and put char that scrolls): the sweep engine walks the store, one cell per cycle
// after reset a clearing pass over the whole cell store runs with cmd.ready low
// one command at a time; a held result stalls the next command beat
module text_console_cell_writer import tcw_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic              clk,
    input  logic              rst_n,
    tcw_cmd_if.sink           cmd,
    tcw_res_if.source         res,
    input  logic              cfg_we,
    input  logic [ATTR_W-1:0] cfg_wdata
);

    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int DEPTH  = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(DEPTH);

    localparam logic [1:0] S_BOOT  = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_READ  = 2'd2;
    localparam logic [1:0] S_SWEEP = 2'd3;

    function automatic logic [ADDR_W-1:0] addr_of(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
        return ADDR_W'(ADDR_W'(r) * ADDR_W'(COLUMNS) + ADDR_W'(c));
    endfunction

    logic [1:0]        state_reg, state_next;
    logic [ATTR_W-1:0] attr_reg;
    logic [ROW_W-1:0]  cur_row_reg, cur_row_next;
    logic [COL_W-1:0]  cur_col_reg, cur_col_next;
    logic              emit_reg, emit_next;
    logic              out_valid_reg, out_valid_next;
    logic [PROW_W-1:0] out_row_reg;
    logic [PCOL_W-1:0] out_col_reg;
    cell_t             out_cell_reg;
    logic              out_err_reg;

    logic              accept;
    logic              in_range;
    logic [ROW_W-1:0]  tgt_row;
    logic [COL_W-1:0]  tgt_col;
    logic [COL_W:0]    col_inc;
    logic [COL_W-1:0]  col_dec;
    logic              wrap;
    logic              at_bottom;
    cell_t             blank;

    swp_cmd_t          swp;
    logic              ld_now, ld_err, ld_read;
    logic              dw_en;
    logic [ADDR_W-1:0] dw_addr;
    cell_t             dw_data;
    logic              dr_en;
    logic [ADDR_W-1:0] dr_addr;

    logic              sw_rd_en, sw_wr_en, sw_done;
    logic [ADDR_W-1:0] sw_rd_addr, sw_wr_addr;
    cell_t             sw_wr_data;
    cell_t             ram_rdata;

    // handshake and decode helpers
    assign cmd.ready = (state_reg == S_IDLE) && (!out_valid_reg || res.ready);
    assign accept    = cmd.valid && cmd.ready;
    assign in_range  = (32'(cmd.row) < ROWS) && (32'(cmd.col) < COLUMNS);
    assign tgt_row   = cmd.row[ROW_W-1:0];
    assign tgt_col   = cmd.col[COL_W-1:0];
    assign col_inc   = (COL_W+1)'(cur_col_reg) + 1'b1;
    assign col_dec   = cur_col_reg - 1'b1;
    assign wrap      = 32'(col_inc) >= COLUMNS;
    assign at_bottom = cur_row_reg == ROW_W'(ROWS - 1);
    assign blank     = {attr_reg, CH_SPACE};

    // command control
    always_comb
    begin
        state_next   = state_reg;
        cur_row_next = cur_row_reg;
        cur_col_next = cur_col_reg;
        emit_next    = emit_reg;
        swp          = '0;
        ld_now       = 1'b0;
        ld_err       = 1'b0;
        ld_read      = 1'b0;
        dw_en        = 1'b0;
        dw_addr      = addr_of(cur_row_reg, cur_col_reg);
        dw_data      = {attr_reg, cmd.char_code};
        dr_en        = 1'b0;
        dr_addr      = addr_of(tgt_row, tgt_col);

        unique case (state_reg)
            S_BOOT:
            begin
                swp.start  = 1'b1;
                swp.mode   = SWP_FILL;
                emit_next  = 1'b0;
                state_next = S_SWEEP;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd.kind)
                        KIND_PUT:
                        begin
                            priority if (cmd.char_code == CH_NEWLINE)
                            begin
                                cur_col_next = '0;
                                if (at_bottom)
                                begin
                                    swp.start  = 1'b1;
                                    swp.mode   = SWP_UP;
                                    swp.lines  = LINES_W'(1);
                                    emit_next  = 1'b1;
                                    state_next = S_SWEEP;
                                end
                                else
                                begin
                                    cur_row_next = cur_row_reg + 1'b1;
                                    ld_now       = 1'b1;
                                end
                            end
                            else if (cmd.char_code == CH_RETURN)
                            begin
                                cur_col_next = '0;
                                ld_now       = 1'b1;
                            end
                            else if (cmd.char_code == CH_BACKSPACE)
                            begin
                                if (cur_col_reg != '0)
                                begin
                                    cur_col_next = col_dec;
                                    dw_en        = 1'b1;
                                    dw_addr      = addr_of(cur_row_reg, col_dec);
                                    dw_data      = blank;
                                end
                                ld_now = 1'b1;
                            end
                            else
                            begin
                                dw_en = 1'b1;
                                if (wrap)
                                begin
                                    cur_col_next = '0;
                                    if (at_bottom)
                                    begin
                                        swp.start  = 1'b1;
                                        swp.mode   = SWP_UP;
                                        swp.lines  = LINES_W'(1);
                                        emit_next  = 1'b1;
                                        state_next = S_SWEEP;
                                    end
                                    else
                                    begin
                                        cur_row_next = cur_row_reg + 1'b1;
                                        ld_now       = 1'b1;
                                    end
                                end
                                else
                                begin
                                    cur_col_next = col_inc[COL_W-1:0];
                                    ld_now       = 1'b1;
                                end
                            end
                        end
                        KIND_SETCUR:
                        begin
                            if (in_range)
                            begin
                                cur_row_next = tgt_row;
                                cur_col_next = tgt_col;
                            end
                            else
                            begin
                                ld_err = 1'b1;
                            end
                            ld_now = 1'b1;
                        end
                        KIND_CLEAR:
                        begin
                            cur_row_next = '0;
                            cur_col_next = '0;
                            swp.start    = 1'b1;
                            swp.mode     = SWP_FILL;
                            emit_next    = 1'b1;
                            state_next   = S_SWEEP;
                        end
                        KIND_WRITE:
                        begin
                            if (in_range)
                            begin
                                dw_en   = 1'b1;
                                dw_addr = addr_of(tgt_row, tgt_col);
                                dw_data = {cmd.cell_attribute, cmd.char_code};
                            end
                            else
                            begin
                                ld_err = 1'b1;
                            end
                            ld_now = 1'b1;
                        end
                        KIND_SCRUP:
                        begin
                            cur_row_next = ROW_W'(ROWS - 1);
                            swp.start    = 1'b1;
                            swp.mode     = SWP_UP;
                            swp.lines    = cmd.line_count;
                            emit_next    = 1'b1;
                            state_next   = S_SWEEP;
                        end
                        KIND_SCRDN:
                        begin
                            swp.start  = 1'b1;
                            swp.mode   = SWP_DOWN;
                            swp.lines  = cmd.line_count;
                            emit_next  = 1'b1;
                            state_next = S_SWEEP;
                        end
                        KIND_READ:
                        begin
                            if (in_range)
                            begin
                                dr_en      = 1'b1;
                                state_next = S_READ;
                            end
                            else
                            begin
                                ld_err = 1'b1;
                                ld_now = 1'b1;
                            end
                        end
                        default:
                        begin
                            ld_now = 1'b1;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                ld_read    = 1'b1;
                state_next = S_IDLE;
            end
            S_SWEEP:
            begin
                if (sw_done)
                begin
                    ld_now     = emit_reg;
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    assign out_valid_next = (out_valid_reg && !res.ready) || ld_now || ld_read;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_BOOT;
            attr_reg      <= ATTR_RESET;
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            emit_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_row_reg   <= cur_row_next;
            cur_col_reg   <= cur_col_next;
            emit_reg      <= emit_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                attr_reg <= cfg_wdata;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (ld_now)
        begin
            out_row_reg  <= PROW_W'(cur_row_next);
            out_col_reg  <= PCOL_W'(cur_col_next);
            out_cell_reg <= '0;
            out_err_reg  <= ld_err;
        end
        else if (ld_read)
        begin
            out_row_reg  <= PROW_W'(cur_row_reg);
            out_col_reg  <= PCOL_W'(cur_col_reg);
            out_cell_reg <= ram_rdata;
            out_err_reg  <= 1'b0;
        end
    end

    assign res.valid          = out_valid_reg;
    assign res.cursor_row_out = out_row_reg;
    assign res.cursor_col_out = out_col_reg;
    assign res.cell_value     = out_cell_reg;
    assign res.position_error = out_err_reg;

    // sweep engine for clear and scroll
    tcw_sweep #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) u_sweep (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (swp),
        .blank   (blank),
        .rd_data (ram_rdata),
        .rd_en   (sw_rd_en),
        .rd_addr (sw_rd_addr),
        .wr_en   (sw_wr_en),
        .wr_addr (sw_wr_addr),
        .wr_data (sw_wr_data),
        .done    (sw_done)
    );

    // cell store
    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (DEPTH)
    ) u_cells (
        .clk   (clk),
        .we    (sw_wr_en || dw_en),
        .waddr (sw_wr_en ? sw_wr_addr : dw_addr),
        .wdata (sw_wr_en ? sw_wr_data : dw_data),
        .re    (sw_rd_en || dr_en),
        .raddr (sw_rd_en ? sw_rd_addr : dr_addr),
        .rdata (ram_rdata)
    );

endmodule

FILE: rtl/tcw_checker.sv
// port-level checker for the text console cell writer and its bind
`include "assert_macros.svh"

module tcw_checker #(
    parameter int ROWS    = 25,
    parameter int COLUMNS = 80
) (
    input logic        clk,
    input logic        rst_n,
    input logic        cmd_valid,
    input logic        cmd_ready,
    input logic        res_valid,
    input logic        res_ready,
    input logic [4:0]  res_row,
    input logic [6:0]  res_col,
    input logic [15:0] res_cell,
    input logic        res_err
);

    // held result beat keeps its payload
    `TCW_ASSERT(a_res_hold, res_valid && !res_ready |=> res_valid && $stable(res_row) && $stable(res_col) && $stable(res_cell) && $stable(res_err), "result beat changed while stalled")

    // no command beat while a result is stuck
    `TCW_ASSERT(a_no_overrun, cmd_valid && cmd_ready |-> !(res_valid && !res_ready), "command taken over a held result")

    // one command at a time: after a beat, either the result shows or input stalls
    `TCW_ASSERT(a_one_at_a_time, cmd_valid && cmd_ready |=> res_valid || !cmd_ready, "second command taken before result")

    // a rejected position reads back zero
    `TCW_ASSERT(a_err_zero, res_valid && res_err |-> res_cell == 16'h0, "error result carries cell data")

    // cursor always on screen
    `TCW_ASSERT(a_cursor_range, res_valid |-> (32'(res_row) < ROWS) && (32'(res_col) < COLUMNS), "cursor off screen")

endmodule

bind text_console_cell_writer tcw_checker #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
) u_tcw_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .res_row   (res.cursor_row_out),
    .res_col   (res.cursor_col_out),
    .res_cell  (res.cell_value),
    .res_err   (res.position_error)
);

FILE: tb/sv/text_console_cell_writer_checker.sv
// checker for the text console cell writer: watches the channels, predicts and compares results
module text_console_cell_writer_checker import tcw_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic              clk,
    input  logic              rst_n,
    tcw_cmd_if                cmd,
    tcw_res_if                res,
    input  logic              cfg_we,
    input  logic [ATTR_W-1:0] cfg_wdata,
    output int                mismatches,
    output int                outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CELLS = ROWS * COLUMNS;

    // one predicted result beat
    typedef struct packed {
        logic [PROW_W-1:0] crow;
        logic [PCOL_W-1:0] ccol;
        cell_t             value;
        logic              perr;
    } console_res_t;

    // shadow copy of the console state
    cell_t             screen [CELLS];
    int unsigned       crs_row;
    int unsigned       crs_col;
    logic [ATTR_W-1:0] text_attr;
    console_res_t      expected_q [$];

    function automatic cell_t blank_cell();
        return {text_attr, CH_SPACE};
    endfunction

    // move every row up one, blank the bottom row, park the cursor on it
    function automatic void roll_up();
        for (int i = 0; i < CELLS - COLUMNS; i++)
            screen[i] = screen[i + COLUMNS];
        for (int i = CELLS - COLUMNS; i < CELLS; i++)
            screen[i] = blank_cell();
        crs_row = ROWS - 1;
    endfunction

    // move every row down one and blank the top row, cursor kept
    function automatic void roll_down();
        for (int i = CELLS - 1; i >= COLUMNS; i--)
            screen[i] = screen[i - COLUMNS];
        for (int i = 0; i < COLUMNS; i++)
            screen[i] = blank_cell();
    endfunction

    function automatic void new_line();
        crs_col = 0;
        crs_row++;
        if (crs_row >= ROWS)
            roll_up();
    endfunction

    // teletype-style character output at the cursor
    function automatic void type_char(logic [CHAR_W-1:0] ch);
        if (ch == CH_NEWLINE)
            new_line();
        else if (ch == CH_RETURN)
            crs_col = 0;
        else if (ch == CH_BACKSPACE)
        begin
            if (crs_col > 0)
            begin
                crs_col--;
                screen[crs_row * COLUMNS + crs_col] = blank_cell();
            end
        end
        else
        begin
            screen[crs_row * COLUMNS + crs_col] = {text_attr, ch};
            crs_col++;
            if (crs_col >= COLUMNS)
                new_line();
        end
    endfunction

    // apply one command to the shadow state and return the result it must produce
    function automatic console_res_t run_command(
        logic [KIND_W-1:0]  kind,
        logic [CHAR_W-1:0]  ch,
        logic [PROW_W-1:0]  r,
        logic [PCOL_W-1:0]  c,
        logic [ATTR_W-1:0]  attr,
        logic [LINES_W-1:0] lines
    );
        int unsigned  n;
        logic         hit;
        console_res_t out;
        n         = (lines == 0) ? 1 : lines;
        hit       = (r < ROWS) && (c < COLUMNS);
        out.value = '0;
        out.perr  = 1'b0;
        case (kind)
            KIND_PUT:
                type_char(ch);
            KIND_SETCUR:
            begin
                if (hit)
                begin
                    crs_row = r;
                    crs_col = c;
                end
                else
                    out.perr = 1'b1;
            end
            KIND_CLEAR:
            begin
                foreach (screen[i])
                    screen[i] = CLEAR_CELL;
                crs_row = 0;
                crs_col = 0;
            end
            KIND_WRITE:
            begin
                if (hit)
                    screen[r * COLUMNS + c] = {attr, ch};
                else
                    out.perr = 1'b1;
            end
            KIND_SCRUP:
                repeat (n) roll_up();
            KIND_SCRDN:
                repeat (n) roll_down();
            KIND_READ:
            begin
                if (hit)
                    out.value = screen[r * COLUMNS + c];
                else
                    out.perr = 1'b1;
            end
            default:
                ;
        endcase
        out.crow = crs_row[PROW_W-1:0];
        out.ccol = crs_col[PCOL_W-1:0];
        return out;
    endfunction

    // report one field, return 1 on a mismatch
    function automatic int field_diff(string name, logic [CELL_W-1:0] want,
                                      logic [CELL_W-1:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // per-edge monitor: result beat first, then register write, then command beat
    always @(posedge clk or negedge rst_n)
    begin : watch
        console_res_t want;
        int           bad;
        if (!rst_n)
        begin
            text_attr = ATTR_RESET;
            crs_row   = 0;
            crs_col   = 0;
            foreach (screen[i])
                screen[i] = CLEAR_CELL;
            expected_q.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            bad = 0;
            if (res.valid && res.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    bad++;
                    $error("result beat with no command waiting");
                end
                else
                begin
                    want = expected_q.pop_front();
                    bad += field_diff("cursor_row_out", want.crow, res.cursor_row_out);
                    bad += field_diff("cursor_col_out", want.ccol, res.cursor_col_out);
                    bad += field_diff("cell_value", want.value, res.cell_value);
                    bad += field_diff("position_error", want.perr, res.position_error);
                end
            end
            if (cfg_we)
                text_attr = cfg_wdata;
            if (cmd.valid && cmd.ready)
                expected_q.push_back(run_command(cmd.kind, cmd.char_code, cmd.row, cmd.col,
                                                 cmd.cell_attribute, cmd.line_count));
            mismatches  <= mismatches + bad;
            outstanding <= expected_q.size();
        end
    end

endmodule

FILE: tb/sv/text_console_cell_writer_tb.sv
// testbench top for the text console cell writer: clock, reset, stimulus and verdict
module text_console_cell_writer_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tcw_pkg::*;

    localparam int COLUMNS      = 80;
    localparam int ROWS         = 25;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 150;
    localparam int CALM_PHASE   = PHASES - 1;

    // kind code with no command behind it
    localparam logic [KIND_W-1:0] KIND_NONE = 3'd7;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [ATTR_W-1:0] cfg_wdata;
    int                mismatches;
    int                outstanding;
    bit                idle_en;
    logic [PROW_W-1:0] last_row;
    logic [PCOL_W-1:0] last_col;

    tcw_cmd_if cmd ();
    tcw_res_if res ();

    text_console_cell_writer #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    text_console_cell_writer_checker #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .res         (res),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit, far above the slowest legal run
    initial
    begin
        #100_000_000;
        $display("tb: failure");
        $finish;
    end

    // result side: random stall bursts while idling is enabled
    initial
    begin : result_sink
        res.ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (idle_en && $urandom_range(0, 5) == 0)
            begin
                res.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
                res.ready <= 1'b1;
            end
        end
    end

    // present one command and hold it until its beat
    task automatic send_cmd(input logic [KIND_W-1:0] k, input logic [CHAR_W-1:0] ch,
                            input logic [PROW_W-1:0] r, input logic [PCOL_W-1:0] c,
                            input logic [ATTR_W-1:0] a, input logic [LINES_W-1:0] n);
        cmd.valid          <= 1'b1;
        cmd.kind           <= k;
        cmd.char_code      <= ch;
        cmd.row            <= r;
        cmd.col            <= c;
        cmd.cell_attribute <= a;
        cmd.line_count     <= n;
        do
            @(posedge clk);
        while (!cmd.ready);
    endtask

    task automatic hold_off(input int cycles);
        cmd.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // stop sending until every result is back
    task automatic drain();
        cmd.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic set_attr(input logic [ATTR_W-1:0] value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // one random command, character output most often, mostly in-range positions
    task automatic send_random();
        int unsigned       pick;
        logic [KIND_W-1:0] k;
        logic [CHAR_W-1:0] ch;
        logic [PROW_W-1:0] r;
        logic [PCOL_W-1:0] c;
        pick = $urandom_range(0, 99);
        ch   = CHAR_W'($urandom);
        r    = PROW_W'($urandom);
        c    = PCOL_W'($urandom);
        if ($urandom_range(0, 5) != 0)
        begin
            r = PROW_W'($urandom_range(0, ROWS - 1));
            c = PCOL_W'($urandom_range(0, COLUMNS - 1));
        end
        if (pick < 45)
        begin
            k = KIND_PUT;
            case ($urandom_range(0, 19))
                0:       ch = CH_NEWLINE;
                1:       ch = CH_RETURN;
                2, 3:    ch = CH_BACKSPACE;
                4:       ch = CHAR_W'($urandom);
                default: ch = CHAR_W'($urandom_range(8'h21, 8'h7E));
            endcase
        end
        else if (pick < 57)
            k = KIND_SETCUR;
        else if (pick < 69)
            k = KIND_WRITE;
        else if (pick < 88)
        begin
            k = KIND_READ;
            // read back the last written cell half of the time
            if ($urandom_range(0, 1) == 0)
            begin
                r = last_row;
                c = last_col;
            end
        end
        else if (pick < 91)
            k = KIND_SCRUP;
        else if (pick < 94)
            k = KIND_SCRDN;
        else if (pick < 95)
            k = KIND_CLEAR;
        else
            k = KIND_NONE;
        if (k == KIND_WRITE)
        begin
            last_row = r;
            last_col = c;
        end
        send_cmd(k, ch, r, c, ATTR_W'($urandom), LINES_W'($urandom));
    endtask

    // stimulus
    initial
    begin : stimulus
        logic [ATTR_W-1:0] attr_plan [PHASES];
        cmd.valid          <= 1'b0;
        cmd.kind           <= KIND_PUT;
        cmd.char_code      <= '0;
        cmd.row            <= '0;
        cmd.col            <= '0;
        cmd.cell_attribute <= '0;
        cmd.line_count     <= '0;
        cfg_we             <= 1'b0;
        cfg_wdata          <= ATTR_RESET;
        rst_n              <= 1'b0;
        idle_en  = 1'b0;
        last_row = '0;
        last_col = '0;
        attr_plan = '{8'h00, 8'hFF, ATTR_W'($urandom), ATTR_W'($urandom), 8'h70, ATTR_RESET};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset contents, backspace, wrap with scroll, bad positions, scroll extremes
        send_cmd(KIND_READ, 8'h00, 0, 0, 8'h00, 0);
        send_cmd(KIND_PUT, 8'h41, 0, 0, 8'h00, 0);
        send_cmd(KIND_PUT, CH_BACKSPACE, 0, 0, 8'h00, 0);
        send_cmd(KIND_PUT, CH_BACKSPACE, 0, 0, 8'h00, 0);
        send_cmd(KIND_READ, 8'h00, 0, 0, 8'h00, 0);
        send_cmd(KIND_SETCUR, 8'h00, ROWS - 1, COLUMNS - 1, 8'h00, 0);
        send_cmd(KIND_PUT, 8'hFF, 0, 0, 8'h00, 0);
        send_cmd(KIND_READ, 8'h00, ROWS - 2, COLUMNS - 1, 8'h00, 0);
        send_cmd(KIND_SETCUR, 8'h00, ROWS, 0, 8'h00, 0);
        send_cmd(KIND_SETCUR, 8'h00, 0, COLUMNS, 8'h00, 0);
        send_cmd(KIND_SETCUR, 8'hFF, 31, 127, 8'hFF, 31);
        send_cmd(KIND_WRITE, 8'hFF, ROWS - 1, COLUMNS - 1, 8'hFF, 0);
        send_cmd(KIND_WRITE, 8'h00, 0, 0, 8'h00, 0);
        send_cmd(KIND_WRITE, 8'h55, 31, 127, 8'hAA, 0);
        send_cmd(KIND_READ, 8'h00, ROWS - 1, COLUMNS - 1, 8'h00, 0);
        send_cmd(KIND_READ, 8'h00, 0, 127, 8'h00, 0);
        send_cmd(KIND_PUT, CH_RETURN, 0, 0, 8'h00, 0);
        send_cmd(KIND_PUT, CH_NEWLINE, 0, 0, 8'h00, 0);
        send_cmd(KIND_SCRUP, 8'h00, 0, 0, 8'h00, 0);
        send_cmd(KIND_SCRDN, 8'h00, 0, 0, 8'h00, 31);
        send_cmd(KIND_SCRUP, 8'h00, 0, 0, 8'h00, 31);
        send_cmd(KIND_READ, 8'h00, ROWS - 1, 0, 8'h00, 0);
        send_cmd(KIND_CLEAR, 8'h00, 0, 0, 8'h00, 0);
        send_cmd(KIND_NONE, 8'hFF, 31, 127, 8'hFF, 31);
        send_cmd(KIND_READ, 8'h00, ROWS - 1, COLUMNS - 1, 8'h00, 0);

        // random phases, each under its own text attribute; the last one runs flat out
        for (int p = 0; p < PHASES; p++)
        begin
            set_attr(attr_plan[p]);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                idle_en = (p != CALM_PHASE) && ((i / 40) % 3 != 2);
                if (idle_en && $urandom_range(0, 3) == 0)
                    hold_off($urandom_range(1, 9));
                send_random();
            end
        end

        // wind down
        idle_en = 1'b0;
        drain();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
